>>> rtl/rtz_pkg.sv
// rtz_pkg: shared types and constants for the radial to z-depth converter
// no dependencies
package rtz_pkg;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int DEPTH_W    = 16;
	localparam int PIX_W      = 12;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FOCAL_X  = 2'd0,
		REG_FOCAL_Y  = 2'd1,
		REG_CENTER_X = 2'd2,
		REG_CENTER_Y = 2'd3
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] FOCAL_MIN   = 20'd256;
	localparam logic [CFG_DATA_W-1:0] FOCAL_RESET = 20'd256;

	// normalized coordinate divider, numerator holds offset << 16 plus half focal
	localparam int NRM_NUM_W = 37;
	localparam int NRM_QUO_W = 28;
	// squared radius and its root
	localparam int SUM_W  = 58;
	localparam int ROOT_W = SUM_W / 2 + 1;
	// final depth divider
	localparam int ZD_NUM_W = 34;
	localparam int ZD_DEN_W = ROOT_W + 1;

endpackage

>>> rtl/rtz_udiv.sv
// rtz_udiv: pipelined restoring divider, one quotient bit per register stage
// standalone, no package use
module rtz_udiv #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 20,
	parameter int QUO_W = 28
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [NUM_W-1:0] hi;
		logic             ge;
		logic [NUM_W-1:0] sub;

		assign hi  = rem_s[k] >> B;
		assign ge  = ({{DEN_W{1'b0}}, hi} >= {{NUM_W{1'b0}}, den_s[k]});
		assign sub = rem_s[k] - (NUM_W'(den_s[k]) << B);

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? sub : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_s[k] | (QUO_W'(ge) << B);
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

>>> rtl/rtz_isqrt.sv
// rtz_isqrt: pipelined integer square root, one root bit per register stage
// standalone, no package use
module rtz_isqrt #(
	parameter int V_W = 58
) (
	input  logic           clk,
	input  logic [V_W-1:0] val,
	output logic [V_W/2:0] root
);

	localparam int N     = V_W / 2 + 1;
	localparam int RES_W = V_W + 2;

	logic [V_W-1:0]   v_s   [0:N];
	logic [RES_W-1:0] res_s [0:N];

	assign v_s[0]   = val;
	assign res_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [RES_W-1:0] BIT = RES_W'(1) << (V_W - 2 * k);
		logic [RES_W-1:0] trial;
		logic             ge;

		assign trial = res_s[k] + BIT;
		assign ge    = ({2'b00, v_s[k]} >= trial);

		always_ff @(posedge clk) begin
			v_s[k+1]   <= ge ? (v_s[k] - trial[V_W-1:0]) : v_s[k];
			res_s[k+1] <= ge ? ((res_s[k] >> 1) + BIT) : (res_s[k] >> 1);
		end
	end

	assign root = res_s[N][V_W/2:0];

endmodule

>>> rtl/radial_to_z_depth.sv
// radial_to_z_depth: radial to planar depth, z = d / sqrt(x*x + y*y + 1)
// one beat accepted every cycle, busy stays low
// stages in order: clamp and offset, coordinate dividers, squares, radius sum, root, depth numerator, depth divider
// arst_n clears the valid pipeline and loads the intrinsics reset values
// uses rtz_pkg, rtz_udiv, rtz_isqrt
module radial_to_z_depth
	import rtz_pkg::*;
#(
	parameter int IMAGE_ROWS = 4096,
	parameter int IMAGE_COLS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [DEPTH_W-1:0]    radial_depth,
	input  logic [PIX_W-1:0]      pixel_row,
	input  logic [PIX_W-1:0]      pixel_col,
	output logic                  done,
	output logic [DEPTH_W-1:0]    z_depth,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int D_DLY = NRM_QUO_W + 2 + ROOT_W;
	localparam int LAT   = 1 + D_DLY + 1 + DEPTH_W;

	logic [CFG_DATA_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_FOCAL_X:  focal_x_q  <= cfg_wdata;
				REG_FOCAL_Y:  focal_y_q  <= cfg_wdata;
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: clamp and offset
	logic [PIX_W-1:0]      row_c, col_c;
	logic [CFG_DATA_W-1:0] prow, pcol, mag_y, mag_x, fx, fy;

	always_comb begin
		row_c = ({1'b0, pixel_row} >= 13'(IMAGE_ROWS)) ? PIX_W'(IMAGE_ROWS - 1) : pixel_row;
		col_c = ({1'b0, pixel_col} >= 13'(IMAGE_COLS)) ? PIX_W'(IMAGE_COLS - 1) : pixel_col;
		prow  = {row_c, 8'd0};
		pcol  = {col_c, 8'd0};
		mag_x = (pcol >= center_x_q) ? (pcol - center_x_q) : (center_x_q - pcol);
		mag_y = (prow >= center_y_q) ? (prow - center_y_q) : (center_y_q - prow);
		fx    = (focal_x_q < FOCAL_MIN) ? FOCAL_MIN : focal_x_q;
		fy    = (focal_y_q < FOCAL_MIN) ? FOCAL_MIN : focal_y_q;
	end

	logic [NRM_NUM_W-1:0]  nx_s1, ny_s1;
	logic [CFG_DATA_W-1:0] fx_s1, fy_s1;
	logic [DEPTH_W-1:0]    d_s1;

	always_ff @(posedge clk) begin
		nx_s1 <= NRM_NUM_W'({mag_x, 16'd0}) + NRM_NUM_W'(fx >> 1);
		ny_s1 <= NRM_NUM_W'({mag_y, 16'd0}) + NRM_NUM_W'(fy >> 1);
		fx_s1 <= fx;
		fy_s1 <= fy;
		d_s1  <= radial_depth;
	end

	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	// depth delay line alongside the coordinate and root pipelines
	logic [DEPTH_W-1:0] d_dly_q [0:D_DLY];

	assign d_dly_q[0] = d_s1;

	for (genvar i = 0; i < D_DLY; i++) begin : g_ddly
		always_ff @(posedge clk) begin
			d_dly_q[i+1] <= d_dly_q[i];
		end
	end

	logic [NRM_QUO_W-1:0] xq, yq;

	rtz_udiv #(.NUM_W(NRM_NUM_W), .DEN_W(CFG_DATA_W), .QUO_W(NRM_QUO_W)) u_div_x (
		.clk (clk),
		.num (nx_s1),
		.den (fx_s1),
		.quo (xq)
	);

	rtz_udiv #(.NUM_W(NRM_NUM_W), .DEN_W(CFG_DATA_W), .QUO_W(NRM_QUO_W)) u_div_y (
		.clk (clk),
		.num (ny_s1),
		.den (fy_s1),
		.quo (yq)
	);

	// squares, then radius sum
	logic [2*NRM_QUO_W-1:0] xsq_s2, ysq_s2;
	logic [SUM_W-1:0]       sum_s3;

	always_ff @(posedge clk) begin
		xsq_s2 <= xq * xq;
		ysq_s2 <= yq * yq;
		sum_s3 <= SUM_W'(xsq_s2) + SUM_W'(ysq_s2) + (SUM_W'(1) << 32);
	end

	logic [ROOT_W-1:0] root;

	rtz_isqrt #(.V_W(SUM_W)) u_sqrt (
		.clk  (clk),
		.val  (sum_s3),
		.root (root)
	);

	logic [ZD_NUM_W-1:0] zn_s4;
	logic [ZD_DEN_W-1:0] zd_s4;

	always_ff @(posedge clk) begin
		zn_s4 <= {1'b0, d_dly_q[D_DLY], 17'd0} + ZD_NUM_W'(root);
		zd_s4 <= {root, 1'b0};
	end

	rtz_udiv #(.NUM_W(ZD_NUM_W), .DEN_W(ZD_DEN_W), .QUO_W(DEPTH_W)) u_div_z (
		.clk (clk),
		.num (zn_s4),
		.den (zd_s4),
		.quo (z_depth)
	);

endmodule
